>>> rtl/core/lbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsd_pkg: shared types and constants for the lane distance/prune block
// Beat layouts between stages, field widths and default sizes.
// ----------------------------------------------------------------------------
package lbsd_pkg;

    localparam int DIMENSIONS_DEF = 14;
    localparam int LANES_DEF      = 8;
    localparam int CHECK_DIM_DEF  = 8;

    localparam int MAX_LANES = 8;   // lanes carried on the bus
    localparam int VAL_W     = 16;
    localparam int SQ_W      = 31;  // largest square is 2^30
    localparam int SUM_W     = 34;
    localparam int LIMIT_W   = 64;
    localparam int TAG_W     = 32;
    localparam int DONE_W    = 4;

    localparam int IN_FIELDS_W  = MAX_LANES * VAL_W + VAL_W + LIMIT_W + TAG_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = MAX_LANES * SUM_W + MAX_LANES + DONE_W + TAG_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Accepted input beat (lane and query values are two's complement)
    typedef struct packed {
        logic [MAX_LANES-1:0][VAL_W-1:0] lane;
        logic [VAL_W-1:0]                query;
        logic [LIMIT_W-1:0]              limit;
        logic [TAG_W-1:0]                tag;
    } t_in_beat;

    // Beat after the squaring stage
    typedef struct packed {
        logic [MAX_LANES-1:0][SQ_W-1:0] sq;
        logic [LIMIT_W-1:0]             limit;
        logic [TAG_W-1:0]               tag;
    } t_sq_beat;

    // Result beat
    typedef struct packed {
        logic [MAX_LANES-1:0][SUM_W-1:0] lane_dist;
        logic [MAX_LANES-1:0]            mask;
        logic [DONE_W-1:0]               dims;
        logic [TAG_W-1:0]                tag;
    } t_result;

endpackage

>>> rtl/core/lbsd_sq_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsd_sq_stage: input register and per-lane squared difference
// Registers the beat, then registers (query - lane)^2 with 16-bit wrap.
// ----------------------------------------------------------------------------
module lbsd_sq_stage #(
    parameter int LANES = lbsd_pkg::LANES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lbsd_pkg::t_in_beat i_beat,
    output logic              o_valid,
    input  logic              i_ready,
    output lbsd_pkg::t_sq_beat o_sq
);
    import lbsd_pkg::*;

    logic     r_in_valid;
    t_in_beat r_in;
    logic     r_sq_valid;
    t_sq_beat r_sq;
    t_sq_beat n_sq;
    logic     sq_load;
    logic     in_load;

    assign sq_load = !r_sq_valid || i_ready;
    assign in_load = !r_in_valid || sq_load;
    assign o_ready = in_load;
    assign o_valid = r_sq_valid;
    assign o_sq    = r_sq;

    always_comb begin
        logic [VAL_W-1:0] diff;
        logic [VAL_W-1:0] mag;
        logic [2*VAL_W-1:0] prod;
        n_sq       = '0;
        n_sq.limit = r_in.limit;
        n_sq.tag   = r_in.tag;
        for (int k = 0; k < MAX_LANES; k++) begin
            diff = r_in.query - r_in.lane[k];
            // magnitude of the wrapped difference; 0x8000 stays 32768
            mag  = diff[VAL_W-1] ? VAL_W'(~diff + 1'b1) : diff;
            prod = (2*VAL_W)'(mag) * (2*VAL_W)'(mag);
            if (k < LANES) begin
                n_sq.sq[k] = prod[SQ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_sq_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_valid;
            end
            if (sq_load) begin
                r_sq_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_in <= i_beat;
        end
        if (sq_load && r_in_valid) begin
            r_sq <= n_sq;
        end
    end

endmodule

>>> rtl/core/lbsd_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbsd_accum: per-lane accumulation, prune check and result register
// Tracks the dimension position and skip state of the current block.
// ----------------------------------------------------------------------------
module lbsd_accum #(
    parameter int DIMENSIONS = lbsd_pkg::DIMENSIONS_DEF,
    parameter int LANES      = lbsd_pkg::LANES_DEF,
    parameter int CHECK_DIM  = lbsd_pkg::CHECK_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lbsd_pkg::t_sq_beat i_sq,
    output logic               o_valid,
    input  logic               i_ready,
    output lbsd_pkg::t_result  o_result
);
    import lbsd_pkg::*;

    localparam int POS_W = $clog2(DIMENSIONS);
    localparam int CNT_W = $clog2(DIMENSIONS + 1);

    logic [POS_W-1:0]                r_pos;
    logic [POS_W-1:0]                n_pos;
    logic                            r_skip;
    logic                            n_skip;
    logic [MAX_LANES-1:0][SUM_W-1:0] r_sum;
    logic [MAX_LANES-1:0][SUM_W-1:0] n_acc;
    logic                            r_out_valid;
    t_result                         r_out;
    t_result                         n_out;

    logic [CNT_W-1:0]     completed;
    logic                 last;
    logic                 checkpoint;
    logic                 no_prune;
    logic                 prune;
    logic                 emit;
    logic                 fire;
    logic [MAX_LANES-1:0] live;
    logic [MAX_LANES-1:0] lane_ones;

    assign o_ready  = !r_out_valid || i_ready;
    assign fire     = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign completed  = CNT_W'(r_pos) + 1'b1;
    assign last       = completed == CNT_W'(DIMENSIONS);
    assign checkpoint = last || (int'(completed) == CHECK_DIM);
    assign no_prune   = &i_sq.limit;

    always_comb begin
        n_acc     = '0;
        live      = '0;
        lane_ones = '0;
        for (int k = 0; k < MAX_LANES; k++) begin
            if (k < LANES) begin
                // block start clears the running sum
                n_acc[k]     = ((r_pos == '0) ? '0 : r_sum[k]) + SUM_W'(i_sq.sq[k]);
                live[k]      = LIMIT_W'(n_acc[k]) <= i_sq.limit;
                lane_ones[k] = 1'b1;
            end
        end
    end

    assign prune = !no_prune && checkpoint && (live == '0);
    assign emit  = !r_skip && (prune || last);

    always_comb begin
        n_pos  = last ? '0 : POS_W'(completed);
        n_skip = r_skip ? !last : (prune && !last);
    end

    always_comb begin
        n_out      = '0;
        n_out.dims = DONE_W'(completed);
        n_out.tag  = i_sq.tag;
        if (!prune) begin
            n_out.lane_dist = n_acc;
            n_out.mask      = no_prune ? lane_ones : live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_pos  <= n_pos;
                r_skip <= n_skip;
            end
            if (o_ready) begin
                r_out_valid <= fire && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && !r_skip) begin
            r_sum <= n_acc;
        end
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pos) < DIMENSIONS)
        else $error("dimension position past block end");

    a_skip_mid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_pos != '0))
        else $error("skip set at block start");

    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && last) |=> (r_pos == '0) && !r_skip)
        else $error("block did not restart after last dimension");

    a_pruned_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.mask == '0)) |-> (r_out.lane_dist == '0))
        else $error("empty alive mask with nonzero distances");

endmodule

>>> rtl/core/lane_block_squared_distance_prune.sv
// The beat completing a result passes the input, square and result registers.
// Throughput: one input beat per cycle, independent of the result side as long as it drains.
// A block of DIMENSIONS beats yields at most one result (checkpoint prune or final distances).
// Reset (i_rst_n low, synchronous) clears the dimension position, skip flag and all valids.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_block_squared_distance_prune: squared distance with early pruning
// Streams one dimension per beat for up to eight lanes, accumulates
// (query - lane)^2 per lane, and drops blocks whose lanes all exceed the
// limit at the checkpoint or last dimension, unless the limit is all ones.
// ----------------------------------------------------------------------------
module lane_block_squared_distance_prune #(
    parameter int DIMENSIONS = lbsd_pkg::DIMENSIONS_DEF,
    parameter int LANES      = lbsd_pkg::LANES_DEF,
    parameter int CHECK_DIM  = lbsd_pkg::CHECK_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // lane_value_0..7 [127:0], query_value [143:128], prune_limit [207:144],
    // block_tag [239:208]
    input  logic [lbsd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // lane_distance_0..7 [271:0] (34 bits each), alive_lanes [279:272],
    // dims_done [283:280], result_tag [315:284], zero pad [319:316]
    output logic [lbsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import lbsd_pkg::*;

    localparam int Q_LSB     = MAX_LANES * VAL_W;
    localparam int LIMIT_LSB = Q_LSB + VAL_W;
    localparam int TAG_LSB   = LIMIT_LSB + LIMIT_W;
    localparam int MASK_LSB  = MAX_LANES * SUM_W;
    localparam int DONE_LSB  = MASK_LSB + MAX_LANES;
    localparam int RTAG_LSB  = DONE_LSB + DONE_W;

    t_in_beat in_beat;
    t_sq_beat sq_beat;
    logic     sq_valid;
    logic     sq_ready;
    t_result  result;

    // Unpack the slave beat
    always_comb begin
        in_beat = '0;
        for (int k = 0; k < MAX_LANES; k++) begin
            in_beat.lane[k] = s_axis_tdata[k*VAL_W +: VAL_W];
        end
        in_beat.query = s_axis_tdata[Q_LSB +: VAL_W];
        in_beat.limit = s_axis_tdata[LIMIT_LSB +: LIMIT_W];
        in_beat.tag   = s_axis_tdata[TAG_LSB +: TAG_W];
    end

    // Stage 1/2: input register, then registered per-lane squares
    lbsd_sq_stage #(
        .LANES (LANES)
    ) u_sq_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_beat  (in_beat),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_sq    (sq_beat)
    );

    // Stage 3: accumulate, prune decision, result register
    lbsd_accum #(
        .DIMENSIONS (DIMENSIONS),
        .LANES      (LANES),
        .CHECK_DIM  (CHECK_DIM)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sq_valid),
        .o_ready  (sq_ready),
        .i_sq     (sq_beat),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // Pack the master beat, lowest field first
    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < MAX_LANES; k++) begin
            m_axis_tdata[k*SUM_W +: SUM_W] = result.lane_dist[k];
        end
        m_axis_tdata[MASK_LSB +: MAX_LANES] = result.mask;
        m_axis_tdata[DONE_LSB +: DONE_W]    = result.dims;
        m_axis_tdata[RTAG_LSB +: TAG_W]     = result.tag;
    end

endmodule
